// File: hdl/obfm_pkg.sv
// types and codes shared by the matcher controller, datapath and top level
// no dependencies
package obfm_pkg;

  typedef enum logic [1:0] {
    KIND_FILL    = 2'd0,
    KIND_RESTED  = 2'd1,
    KIND_EMPTY   = 2'd2,
    KIND_DROPPED = 2'd3
  } kind_t;

  typedef struct packed {
    logic [15:0] order_id;
    logic        side;
    logic [7:0]  price_tick;
    logic [15:0] quantity;
  } order_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] taker_id;
    logic [15:0] maker_id;
    logic [15:0] fill_qty;
    logic [15:0] remaining_qty;
    logic        last;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic  clr;
    logic  load;
    logic  sel_own;
    logic  lvl_load;
    logic  ent_use;
    logic  lvl_wb;
    logic  rest;
    logic  emit_done;
    kind_t kind;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic in_range;
    logic in_zero;
    logic match_more;
    logic qty_zero;
    logic rd_full;
  } stat_t;

endpackage

// File: hdl/order_book_fifo_matcher.sv
// price-time matcher top level: controller plus datapath
// depends on obfm_pkg, obfm_ctrl, obfm_datapath
//
//  channel   ports                   handshake
//  order     order (order_t)         taken when start && !busy
//  result    result (result_t)       one cycle each, marked by strobe
//
// after reset the level table is swept, all 2*PRICE_LEVELS levels, with busy high
// an order stays busy longer for each fill, whether it rests, its rest is
// dropped because its own level is full, or nothing is left to rest;
// an out of range price goes straight to the done item
// the fill loop is a read then a read-modify-write of the entry memory
// results cannot be held off; a new order may start as the done item shows
module order_book_fifo_matcher import obfm_pkg::*; #(
  parameter int PRICE_LEVELS     = 256,
  parameter int ORDERS_PER_LEVEL = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  order_t  order,
  output logic    busy,
  output logic    strobe,
  output result_t result
);

  cmd_t  cmd;
  stat_t stat;

  obfm_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .stat   (stat),
    .busy   (busy),
    .strobe (strobe),
    .cmd    (cmd)
  );

  obfm_datapath #(
    .PRICE_LEVELS     (PRICE_LEVELS),
    .ORDERS_PER_LEVEL (ORDERS_PER_LEVEL)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .order  (order),
    .cmd    (cmd),
    .stat   (stat),
    .result (result)
  );

  a_done_frees: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last |-> !busy) else $error("done item while busy");

  a_fill_nonzero: assert property (@(posedge clk) disable iff (rst)
    strobe && result.kind == KIND_FILL |-> result.fill_qty != 16'd0 && !result.last)
    else $error("bad fill item");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    strobe && result.kind != KIND_FILL |-> result.last) else $error("done not last");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("order not taken");

endmodule

// File: hdl/obfm_datapath.sv
// level and entry memories, working registers and result register
// depends on obfm_pkg
module obfm_datapath import obfm_pkg::*; #(
  parameter int PRICE_LEVELS     = 256,
  parameter int ORDERS_PER_LEVEL = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  order_t  order,
  input  cmd_t    cmd,
  output stat_t   stat,
  output result_t result
);

  localparam int NLVL = 2 * PRICE_LEVELS;
  localparam int LW   = $clog2(NLVL);
  localparam int EW   = $clog2(NLVL * ORDERS_PER_LEVEL);
  localparam int HW   = (ORDERS_PER_LEVEL > 1) ? $clog2(ORDERS_PER_LEVEL) : 1;
  localparam int CW   = $clog2(ORDERS_PER_LEVEL + 1);
  localparam int VW   = 16 + CW;
  localparam int MW   = HW + CW + VW;

  logic [MW-1:0] lvl_mem [NLVL];
  logic [31:0]   ent_mem [NLVL * ORDERS_PER_LEVEL];

  order_t        ord;
  logic [LW-1:0] lvl;
  logic [LW-1:0] clr_cnt;
  logic [EW-1:0] base;
  logic [HW-1:0] cur_head;
  logic [CW-1:0] cur_count;
  logic [VW-1:0] cur_vol;
  logic [MW-1:0] lvl_rd;
  logic [31:0]   ent_rd;

  logic [HW-1:0] rd_head;
  logic [CW-1:0] rd_count;
  logic [VW-1:0] rd_vol;
  logic [LW-1:0] own_lvl;
  logic          lvl_we;
  logic [LW-1:0] lvl_wa;
  logic [MW-1:0] lvl_wd;
  logic          ent_we;
  logic [EW-1:0] ent_ra, ent_wa;
  logic [31:0]   ent_wd;
  logic [CW:0]   pos_sum;
  logic [HW-1:0] tail_pos, head_adv;
  logic [15:0]   mq, fill, mq_after, qty_after;

  function automatic logic [LW-1:0] level_of(input logic s, input logic [7:0] t);
    logic [LW-1:0] off;
    off = s ? LW'(PRICE_LEVELS) : '0;
    return off + LW'(t);
  endfunction

  assign {rd_head, rd_count, rd_vol} = lvl_rd;
  assign own_lvl = level_of(ord.side, ord.price_tick);

  // ring position of the tail slot and of the head after a removal
  assign pos_sum  = (CW+1)'(cur_head) + (CW+1)'(cur_count);
  assign tail_pos = (pos_sum >= (CW+1)'(ORDERS_PER_LEVEL))
                    ? HW'(pos_sum - (CW+1)'(ORDERS_PER_LEVEL)) : HW'(pos_sum);
  assign head_adv = (cur_head == HW'(ORDERS_PER_LEVEL - 1)) ? '0 : cur_head + HW'(1);

  assign mq        = ent_rd[15:0];
  assign fill      = (mq < ord.quantity) ? mq : ord.quantity;
  assign mq_after  = mq - fill;
  assign qty_after = ord.quantity - fill;

  assign ent_ra = base + EW'(cur_head);

  always_comb begin
    lvl_we = cmd.clr || cmd.lvl_wb || cmd.rest;
    lvl_wa = cmd.clr ? clr_cnt : lvl;
    lvl_wd = '0;
    if (cmd.lvl_wb) begin
      lvl_wd = {cur_head, cur_count, cur_vol};
    end else if (cmd.rest) begin
      lvl_wd = {cur_head, cur_count + CW'(1), cur_vol + VW'(ord.quantity)};
    end
    ent_we = cmd.ent_use || cmd.rest;
    ent_wa = cmd.rest ? base + EW'(tail_pos) : ent_ra;
    ent_wd = cmd.rest ? {ord.order_id, ord.quantity} : {ent_rd[31:16], mq_after};
  end

  always_comb begin
    stat.clr_last   = (clr_cnt == LW'(NLVL - 1));
    stat.in_range   = (32'(order.price_tick) < 32'(PRICE_LEVELS));
    stat.in_zero    = (order.quantity == '0);
    stat.match_more = (ord.quantity != '0) && (cur_count != '0);
    stat.qty_zero   = (ord.quantity == '0);
    stat.rd_full    = (32'(rd_count) >= 32'(ORDERS_PER_LEVEL));
  end

  always_ff @(posedge clk) begin
    if (lvl_we) begin
      lvl_mem[lvl_wa] <= lvl_wd;
    end
    lvl_rd <= lvl_mem[lvl];
    if (ent_we) begin
      ent_mem[ent_wa] <= ent_wd;
    end
    ent_rd <= ent_mem[ent_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr) begin
      clr_cnt <= clr_cnt + LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    base <= EW'(lvl) * EW'(ORDERS_PER_LEVEL);
    if (cmd.load) begin
      ord <= order;
      lvl <= level_of(!order.side, order.price_tick);
    end
    if (cmd.sel_own) begin
      lvl <= own_lvl;
    end
    if (cmd.lvl_load) begin
      cur_head  <= rd_head;
      cur_count <= rd_count;
      cur_vol   <= rd_vol;
    end
    if (cmd.ent_use) begin
      ord.quantity <= qty_after;
      cur_vol      <= cur_vol - VW'(fill);
      if (mq_after == '0) begin
        cur_head  <= head_adv;
        cur_count <= cur_count - CW'(1);
      end
      result <= '{kind: KIND_FILL, taker_id: ord.order_id, maker_id: ent_rd[31:16],
                  fill_qty: fill, remaining_qty: qty_after, last: 1'b0};
    end
    if (cmd.emit_done) begin
      result <= '{kind: cmd.kind, taker_id: ord.order_id, maker_id: 16'd0,
                  fill_qty: 16'd0, remaining_qty: ord.quantity, last: 1'b1};
    end
  end

endmodule

// File: hdl/obfm_ctrl.sv
// sequencer for clearing, matching, write back and resting
// depends on obfm_pkg
module obfm_ctrl import obfm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output logic  busy,
  output logic  strobe,
  output cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LVL_RD, S_LVL_LOAD, S_MATCH, S_ENT_USE,
    S_LVL_WB, S_OWN_RD, S_OWN_LOAD, S_REST, S_DONE
  } state_t;

  state_t state;
  kind_t  done_kind;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.kind      = done_kind;
    cmd.clr       = (state == S_CLEAR);
    cmd.load      = (state == S_IDLE) && start;
    cmd.sel_own   = (state == S_LVL_WB);
    cmd.lvl_load  = (state == S_LVL_LOAD) || (state == S_OWN_LOAD);
    cmd.ent_use   = (state == S_ENT_USE);
    cmd.lvl_wb    = (state == S_LVL_WB);
    cmd.rest      = (state == S_REST);
    cmd.emit_done = (state == S_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      strobe    <= 1'b0;
      done_kind <= KIND_EMPTY;
    end else begin
      strobe <= (state == S_ENT_USE) || (state == S_DONE);
      case (state)
        S_CLEAR: begin
          if (stat.clr_last) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            if (stat.in_range) begin
              state <= S_LVL_RD;
            end else begin
              done_kind <= stat.in_zero ? KIND_EMPTY : KIND_DROPPED;
              state     <= S_DONE;
            end
          end
        end
        S_LVL_RD:   state <= S_LVL_LOAD;
        S_LVL_LOAD: state <= S_MATCH;
        S_MATCH: begin
          state <= stat.match_more ? S_ENT_USE : S_LVL_WB;
        end
        S_ENT_USE:  state <= S_MATCH;
        S_LVL_WB: begin
          if (stat.qty_zero) begin
            done_kind <= KIND_EMPTY;
            state     <= S_DONE;
          end else begin
            state <= S_OWN_RD;
          end
        end
        S_OWN_RD:   state <= S_OWN_LOAD;
        S_OWN_LOAD: begin
          if (stat.rd_full) begin
            done_kind <= KIND_DROPPED;
            state     <= S_DONE;
          end else begin
            done_kind <= KIND_RESTED;
            state     <= S_REST;
          end
        end
        S_REST:     state <= S_DONE;
        S_DONE:     state <= S_IDLE;
        default:    state <= S_IDLE;
      endcase
    end
  end

endmodule
